>>> hdl/glzw_pkg.sv
// Shared types and constants for the GIF LZW decoder.
package glzw_pkg;

  localparam int unsigned TableSizeDef = 4096;
  localparam int unsigned CodeW        = 12;
  localparam int unsigned NfcW         = 13;
  localparam logic [3:0]  ResetMinSize = 4'd8;

  // result status codes
  localparam logic [2:0] StPixel   = 3'd0;
  localparam logic [2:0] StTaken   = 3'd1;
  localparam logic [2:0] StNeed    = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StEnd     = 3'd4;
  localparam logic [2:0] StCorrupt = 3'd5;

  // operation codes on the input stream
  localparam logic [1:0] OpPush   = 2'd0;
  localparam logic [1:0] OpPull   = 2'd1;
  localparam logic [1:0] OpStart  = 2'd2;
  localparam logic [1:0] OpIgnore = 2'd3;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_PULL,
    KIND_START,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  // queue to back end handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

>>> hdl/glzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/glzw_front.sv
// Front end: accepts input transfers, classifies the operation, queues them.
module glzw_front
  import glzw_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] byte_i,
  output q_out_t q_o,
  input  logic   pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      new_item;

  // classify operation
  always_comb begin
    new_item.data = byte_i;
    unique case (op_i)
      OpPush:  new_item.kind = KIND_PUSH;
      OpPull:  new_item.kind = KIND_PULL;
      OpStart: new_item.kind = KIND_START;
      default: new_item.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> hdl/glzw_back.sv
// Back end: bit buffer, code decode, prefix chain walk and result register.
module glzw_back
  import glzw_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] min_size_i,
  input  q_out_t     q_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] pixel_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned DW = $clog2(TABLE_SIZE + 1);
  localparam logic [DW-1:0]   TsD = DW'(TABLE_SIZE);
  localparam logic [NfcW-1:0] TsC = NfcW'(TABLE_SIZE);
  localparam logic [NfcW-1:0] RstClr = NfcW'(1) << ResetMinSize;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_POP    = 6'b000010,
    S_DECODE = 6'b000100,
    S_FETCH  = 6'b001000,
    S_WALK   = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [23:0]      holder_q, holder_d;
  logic [4:0]       bits_q, bits_d;
  logic [DW-1:0]    depth_q, depth_d;
  logic [NfcW-1:0]  nfc_q, nfc_d;
  logic [3:0]       cw_q, cw_d;
  logic [NfcW-1:0]  lim_q, lim_d;
  logic [7:0]       fc_q, fc_d;
  logic [CodeW-1:0] prev_q, prev_d;
  logic             await_q, await_d;
  logic [CodeW-1:0] cur_q, cur_d;
  logic [CodeW-1:0] incode_q, incode_d;
  logic             ovalid_q, ovalid_d;
  logic [2:0]       ostat_q, ostat_d;
  logic [7:0]       opix_q, opix_d;

  logic [3:0]       sz;
  logic [NfcW-1:0]  clr, endc, code_x, nfc_inc;
  logic [CodeW-1:0] code, mask, nxt;
  logic [23:0]      holder_sh;
  logic [31:0]      push_word;

  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [7:0]       st_wdata, st_rdata;
  logic             dc_we;
  logic [AW-1:0]    dc_waddr, dc_raddr;
  logic [CodeW+7:0] dc_wdata, dc_rdata;
  logic [CodeW-1:0] pfx_rd;
  logic [7:0]       sfx_rd;

  // effective minimum code size and special codes
  always_comb begin
    if (min_size_i < 4'd2) begin
      sz = 4'd2;
    end else if (min_size_i > 4'd8) begin
      sz = 4'd8;
    end else begin
      sz = min_size_i;
    end
  end
  assign clr  = NfcW'(1) << sz;
  assign endc = clr + NfcW'(1);

  // code extraction from the LSB-first bit buffer
  assign mask      = CodeW'((NfcW'(1) << cw_q) - NfcW'(1));
  assign code      = holder_q[CodeW-1:0] & mask;
  assign code_x    = {1'b0, code};
  assign holder_sh = holder_q >> cw_q;
  assign push_word = {8'd0, holder_q} | ({24'd0, q_i.item.data} << bits_q);
  assign nfc_inc   = nfc_q + NfcW'(1);
  assign pfx_rd    = dc_rdata[CodeW+7:8];
  assign sfx_rd    = dc_rdata[7:0];
  assign nxt       = pfx_rd;

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign pixel_o     = opix_q;

  always_comb begin
    state_d  = state_q;
    holder_d = holder_q;
    bits_d   = bits_q;
    depth_d  = depth_q;
    nfc_d    = nfc_q;
    cw_d     = cw_q;
    lim_d    = lim_q;
    fc_d     = fc_q;
    prev_d   = prev_q;
    await_d  = await_q;
    cur_d    = cur_q;
    incode_d = incode_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ostat_d  = ostat_q;
    opix_d   = opix_q;
    pop_o    = 1'b0;
    st_we    = 1'b0;
    st_waddr = depth_q[AW-1:0];
    st_wdata = fc_q;
    st_raddr = depth_q[AW-1:0] - AW'(1);
    dc_we    = 1'b0;
    dc_waddr = nfc_q[AW-1:0];
    dc_wdata = {prev_q, cur_q[7:0]};
    dc_raddr = cur_q[AW-1:0];

    unique case (state_q)
      // take the next queued item once the result slot is free
      S_IDLE: begin
        if (q_i.valid && !ovalid_q) begin
          pop_o = 1'b1;
          unique case (q_i.item.kind)
            KIND_START: begin
              holder_d = '0;
              bits_d   = '0;
              fc_d     = '0;
              prev_d   = '0;
              nfc_d    = clr + NfcW'(2);
              cw_d     = sz + 4'd1;
              lim_d    = clr << 1;
              depth_d  = '0;
              await_d  = 1'b1;
            end
            KIND_PUSH: begin
              ovalid_d = 1'b1;
              opix_d   = '0;
              if (bits_q > 5'd16) begin
                ostat_d = StFull;
              end else begin
                holder_d = push_word[23:0];
                bits_d   = bits_q + 5'd8;
                ostat_d  = StTaken;
              end
            end
            KIND_PULL: begin
              if (depth_q != '0) begin
                state_d = S_POP;
              end else begin
                state_d = S_DECODE;
              end
            end
            default: ;
          endcase
        end
      end

      // stack read data is ready
      S_POP: begin
        depth_d  = depth_q - DW'(1);
        ovalid_d = 1'b1;
        ostat_d  = StPixel;
        opix_d   = st_rdata;
        state_d  = S_IDLE;
      end

      // one code per cycle; clear codes loop here
      S_DECODE: begin
        opix_d = '0;
        if (bits_q < {1'b0, cw_q}) begin
          ovalid_d = 1'b1;
          ostat_d  = StNeed;
          state_d  = S_IDLE;
        end else begin
          holder_d = holder_sh;
          bits_d   = bits_q - {1'b0, cw_q};
          if (code_x == clr) begin
            nfc_d   = clr + NfcW'(2);
            cw_d    = sz + 4'd1;
            lim_d   = clr << 1;
            depth_d = '0;
            await_d = 1'b1;
          end else if (code_x == endc) begin
            ovalid_d = 1'b1;
            ostat_d  = StEnd;
            state_d  = S_IDLE;
          end else if (await_q) begin
            ovalid_d = 1'b1;
            state_d  = S_IDLE;
            if (code_x > endc) begin
              ostat_d = StCorrupt;
            end else begin
              fc_d    = code[7:0];
              prev_d  = code;
              await_d = 1'b0;
              ostat_d = StPixel;
              opix_d  = code[7:0];
            end
          end else if (code_x > nfc_q) begin
            ovalid_d = 1'b1;
            ostat_d  = StCorrupt;
            state_d  = S_IDLE;
          end else begin
            incode_d = code;
            if (code_x == nfc_q) begin
              // KwKwK: the string is previous plus its own first char
              if (depth_q >= TsD) begin
                depth_d  = '0;
                ovalid_d = 1'b1;
                ostat_d  = StCorrupt;
                state_d  = S_IDLE;
              end else begin
                st_we   = 1'b1;
                depth_d = depth_q + DW'(1);
                cur_d   = prev_q;
                state_d = ({1'b0, prev_q} >= clr) ? S_FETCH : S_FINISH;
              end
            end else begin
              cur_d   = code;
              state_d = (code_x >= clr) ? S_FETCH : S_FINISH;
            end
          end
        end
      end

      // issue the dictionary read for the current chain link
      S_FETCH: begin
        if ({1'b0, cur_q} >= TsC) begin
          depth_d  = '0;
          ovalid_d = 1'b1;
          ostat_d  = StCorrupt;
          opix_d   = '0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_WALK;
        end
      end

      // push the suffix and follow the prefix
      S_WALK: begin
        if (depth_q >= TsD || pfx_rd == cur_q) begin
          depth_d  = '0;
          ovalid_d = 1'b1;
          ostat_d  = StCorrupt;
          opix_d   = '0;
          state_d  = S_IDLE;
        end else begin
          st_we    = 1'b1;
          st_wdata = sfx_rd;
          depth_d  = depth_q + DW'(1);
          cur_d    = nxt;
          state_d  = ({1'b0, nxt} >= clr) ? S_FETCH : S_FINISH;
        end
      end

      // root reached: its char is pushed and popped at once
      S_FINISH: begin
        fc_d     = cur_q[7:0];
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
        if (depth_q >= TsD) begin
          depth_d = '0;
          ostat_d = StCorrupt;
          opix_d  = '0;
        end else begin
          ostat_d = StPixel;
          opix_d  = cur_q[7:0];
          prev_d  = incode_q;
          if (nfc_q < TsC) begin
            dc_we = 1'b1;
            nfc_d = nfc_inc;
            if (nfc_inc >= lim_q && lim_q < TsC) begin
              lim_d = lim_q << 1;
              cw_d  = cw_q + 4'd1;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      holder_q <= '0;
      bits_q   <= '0;
      depth_q  <= '0;
      nfc_q    <= RstClr + NfcW'(2);
      cw_q     <= ResetMinSize + 4'd1;
      lim_q    <= RstClr << 1;
      fc_q     <= '0;
      prev_q   <= '0;
      await_q  <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      holder_q <= holder_d;
      bits_q   <= bits_d;
      depth_q  <= depth_d;
      nfc_q    <= nfc_d;
      cw_q     <= cw_d;
      lim_q    <= lim_d;
      fc_q     <= fc_d;
      prev_q   <= prev_d;
      await_q  <= await_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    incode_q <= incode_d;
    ostat_q  <= ostat_d;
    opix_q   <= opix_d;
  end

  // expansion stack
  glzw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // dictionary: prefix and suffix side by side
  glzw_ram #(
    .WIDTH (CodeW + 8),
    .DEPTH (TABLE_SIZE)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (dc_we),
    .waddr_i (dc_waddr),
    .wdata_i (dc_wdata),
    .raddr_i (dc_raddr),
    .rdata_o (dc_rdata)
  );

endmodule

>>> hdl/gif_lzw_decoder_top.sv
// GIF LZW decoder: a push result is registered after the item has passed the input queue.
// A pull from a loaded stack reads the stack RAM in S_POP; a pull that takes a new code
// decodes it in S_DECODE, which also consumes clear codes, then walks its chain through
// S_FETCH and S_WALK (one dictionary RAM read per link) and adds a dictionary entry in S_FINISH.
// A new item starts once the previous result has left; up to two items wait in the queue.
// Reset clears the bit buffer and stack and sets up the dictionary for code size 8;
// dictionary and stack memories are not cleared and need no clearing pass.
module gif_lzw_decoder_top
  import glzw_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,      // min_code_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,     // [1:0] operation, [9:2] data_byte, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata      // [2:0] status, [10:3] pixel_index, rest zero
);

  logic [3:0] min_size_q;
  q_out_t     q;
  logic       pop;
  logic [2:0] status;
  logic [7:0] pixel;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= ResetMinSize;
    end else if (cfg_we_i) begin
      min_size_q <= cfg_wdata_i;
    end
  end

  glzw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[1:0]),
    .byte_i     (s_axis_tdata[9:2]),
    .q_o        (q),
    .pop_i      (pop)
  );

  glzw_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_size_i  (min_size_q),
    .q_i         (q),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .pixel_o     (pixel)
  );

  assign m_axis_tdata = {5'd0, pixel, status};

endmodule

>>> test/gif_lzw_decoder_top_tb.sv
// Self-checking stream testbench for the GIF LZW decoder top level.
module gif_lzw_decoder_top_tb;
  import glzw_pkg::*;

  localparam int unsigned TSIZE = 4096;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd8;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  gif_lzw_decoder_top #(.TABLE_SIZE(TSIZE)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  // decoder shadow state
  logic [3:0]  lzw_min_size;
  logic [23:0] hold_bits;
  int unsigned hold_cnt;
  logic [11:0] dict_prefix [TSIZE];
  logic [7:0]  dict_suffix [TSIZE];
  logic [7:0]  pix_stack [TSIZE];
  int unsigned stack_top, free_code, cur_width, grow_at, prev_code;
  logic [7:0]  first_pix;
  bit          want_first;

  logic [15:0] pending_items [$];
  logic [10:0] expected_pixels [$];
  int unsigned failures = 0;
  int unsigned idle_pct = 0, stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic int unsigned clamp_size();
    if (lzw_min_size < 2) return 2;
    if (lzw_min_size > 8) return 8;
    return lzw_min_size;
  endfunction

  function automatic void reset_dict();
    free_code  = (1 << clamp_size()) + 2;
    cur_width  = clamp_size() + 1;
    grow_at    = 2 * (1 << clamp_size());
    stack_top  = 0;
    want_first = 1'b1;
  endfunction

  function automatic void new_image();
    hold_bits = '0;
    hold_cnt  = 0;
    first_pix = '0;
    prev_code = 0;
    reset_dict();
  endfunction

  function automatic bit stack_put(logic [7:0] v);
    if (stack_top >= TSIZE) return 1'b0;
    pix_stack[stack_top] = v;
    stack_top++;
    return 1'b1;
  endfunction

  // fetch one code and expand it
  function automatic logic [2:0] decode_code(output logic [7:0] pix);
    int unsigned clr, code, incode;
    clr = 1 << clamp_size();
    pix = '0;
    forever begin
      if (hold_cnt < cur_width) return StNeed;
      code = hold_bits & ((1 << cur_width) - 1);
      hold_bits = hold_bits >> cur_width;
      hold_cnt -= cur_width;
      if (code == clr) begin
        reset_dict();
        continue;
      end
      if (code == clr + 1) return StEnd;
      if (want_first) begin
        if (code > clr + 1) return StCorrupt;
        first_pix = code[7:0];
        prev_code = code;
        want_first = 1'b0;
        pix = code[7:0];
        return StPixel;
      end
      if (code > free_code) return StCorrupt;
      incode = code;
      if (code == free_code) begin
        if (!stack_put(first_pix)) begin
          stack_top = 0;
          return StCorrupt;
        end
        code = prev_code;
      end
      while (code >= clr) begin
        if (code >= TSIZE || !stack_put(dict_suffix[code]) || dict_prefix[code] == code) begin
          stack_top = 0;
          return StCorrupt;
        end
        code = dict_prefix[code];
      end
      first_pix = code[7:0];
      if (!stack_put(first_pix)) begin
        stack_top = 0;
        return StCorrupt;
      end
      if (free_code < TSIZE) begin
        dict_prefix[free_code] = prev_code[11:0];
        dict_suffix[free_code] = first_pix;
        free_code++;
        if (free_code >= grow_at && grow_at < TSIZE) begin
          grow_at <<= 1;
          cur_width++;
        end
      end
      prev_code = incode;
      stack_top--;
      pix = pix_stack[stack_top];
      return StPixel;
    end
  endfunction

  // apply one accepted input transfer to the shadow state
  function automatic void predict_item(logic [15:0] d);
    logic [1:0]  op;
    logic [7:0]  b, pix;
    logic [2:0]  st;
    op = d[1:0];
    b = d[9:2];
    pix = '0;
    if (op == OpStart) begin
      new_image();
      return;
    end
    if (op != OpPush && op != OpPull) return;
    if (op == OpPush) begin
      if (hold_cnt + 8 > 24) st = StFull;
      else begin
        hold_bits = hold_bits | (24'(b) << hold_cnt);
        hold_cnt += 8;
        st = StTaken;
      end
    end else if (stack_top > 0) begin
      stack_top--;
      pix = pix_stack[stack_top];
      st = StPixel;
    end else st = decode_code(pix);
    expected_pixels.push_back({(st == StPixel) ? pix : 8'd0, st});
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_items.pop_front();
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // output monitor and ready generation
  always @(posedge clk_i) begin
    logic [10:0] exp_v;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        failures++;
        $display("%0t: expected no result, got %h", $realtime, m_axis_tdata);
      end else begin
        exp_v = expected_pixels.pop_front();
        if (m_axis_tdata[2:0] != exp_v[2:0] || m_axis_tdata[10:3] != exp_v[10:3]
            || m_axis_tdata[15:11] != 0) begin
          failures++;
          $display("%0t: status exp %0d got %0d, pixel exp %0d got %0d", $realtime,
                   exp_v[2:0], m_axis_tdata[2:0], exp_v[10:3], m_axis_tdata[10:3]);
        end
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted in its own process
  task automatic hold_output(int unsigned n);
    hold_off = 1'b1;
    repeat (n) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_min_size(logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    lzw_min_size = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_item(logic [1:0] op, logic [7:0] b);
    pending_items.push_back({6'd0, b, op});
  endfunction

  // LSB-first code packer producing push/pull items for a valid stream
  int unsigned pk_bits, pk_cnt;
  function automatic void pack_code(int unsigned code, int unsigned w);
    pk_bits |= code << pk_cnt;
    pk_cnt += w;
    while (pk_cnt >= 8) begin
      add_item(OpPush, pk_bits[7:0]);
      pk_bits >>= 8;
      pk_cnt -= 8;
      // drain with pulls at random, so the holder mostly has room
      if ($urandom_range(3) != 0) add_item(OpPull, 8'd0);
    end
  endfunction

  // emit a random code sequence; sizes tracked like an encoder would, but mid-stream clears use the reset width
  function automatic void legal_stream(int unsigned sz, int unsigned ncodes);
    int unsigned clr, nf, w, lim, c;
    bit first;
    clr = 1 << sz;
    nf = clr + 2; w = sz + 1; lim = 2 * clr; first = 1;
    pk_bits = 0; pk_cnt = 0;
    add_item(OpStart, 8'($urandom));
    pack_code(clr, w);
    for (int i = 0; i < ncodes; i++) begin
      if (first) begin
        c = $urandom_range(clr - 1);
        first = 0;
      end else if ($urandom_range(40) == 0) begin
        c = clr;
        nf = clr + 2; w = sz + 1; lim = 2 * clr; first = 1;
        pack_code(c, sz + 1);
        continue;
      end else begin
        c = ($urandom_range(1)) ? $urandom_range(clr - 1) : $urandom_range(nf, clr + 2);
        if (c == clr || c == clr + 1) c = nf;
      end
      pack_code(c, w);
      if (i > 0 && c != clr && nf < TSIZE) begin
        nf++;
        if (nf >= lim && lim < TSIZE) begin
          lim <<= 1; w++;
        end
      end
    end
    pack_code(clr + 1, w);
    if (pk_cnt > 0) add_item(OpPush, pk_bits[7:0]);
    repeat (12) add_item(OpPull, 8'd0);
  endfunction

  // idle phases: none, sender, receiver, both
  task automatic set_phase(int unsigned p);
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 74; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 74; end
      default: begin idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  initial begin
    lzw_min_size = 4'd8;
    new_image();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: edge cases at size 2
    set_min_size(4'd2);
    add_item(OpStart, 8'h00);
    add_item(OpPull, 8'hff);               // need data
    add_item(OpPush, 8'h00);               // codes 0 and 0
    add_item(OpPush, 8'hff);
    add_item(OpPush, 8'hff);
    add_item(OpPush, 8'hff);               // holder full
    add_item(OpIgnore, 8'haa);             // ignored op
    repeat (6) add_item(OpPull, 8'd0);
    add_item(OpStart, 8'h00);
    add_item(OpPush, 8'b0000_0110);        // first code 6 -> corrupt
    add_item(OpPull, 8'd0);
    add_item(OpStart, 8'h00);
    add_item(OpPush, 8'b0010_1001);        // 1, then 5 end code
    add_item(OpPull, 8'd0);
    add_item(OpPull, 8'd0);
    add_item(OpPull, 8'd0);
    wait_drained();

    // out-of-range sizes clamp
    set_min_size(4'd0);
    legal_stream(2, 20);
    wait_drained();
    set_min_size(4'd15);
    legal_stream(8, 20);
    wait_drained();

    // random phases across sizes
    for (int ph = 0; ph < 16; ph++) begin
      set_phase(ph);
      set_min_size((ph % 5 == 0) ? 4'd8 : 4'($urandom_range(2, 8)));
      legal_stream(clamp_size(), $urandom_range(8, 22));
      for (int k = 0; k < 6; k++) add_item(2'($urandom_range(1)), 8'($urandom));
      if (ph == 6) begin
        fork
          hold_output(400);
        join_none
      end
      wait_drained();
    end
    set_phase(0);
    set_min_size(4'd8);
    legal_stream(8, 20);
    wait_drained();

    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
